/* hw/rtl/obbfaot_pkg.sv */
// ----------------------------------------------------------------------------
// obbfaot_pkg
// Shared types, codes and row-address tables for the box face-axis overlap
// tester.
// ----------------------------------------------------------------------------
package obbfaot_pkg;

    // Vector store: 2 boxes x 4 vectors, one row per vector
    localparam int VEC_ROWS = 8;
    localparam int ROW_W    = 3;

    // Axis sweep bounds: six face axes, seven dot products per axis
    localparam logic [2:0] AXIS_LAST = 3'd5;
    localparam logic [2:0] TERM_LAST = 3'd6;

    // Last value of the drain counter that waits for the flag to settle
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    // Command codes of an input beat
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } cmd_code_t;

    // Controller to datapath command bundle
    typedef struct packed {
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [ROW_W-1:0] rd_a_row;
        logic [ROW_W-1:0] rd_b_row;
        logic             d_load;
        logic             sep_clr;
        logic             issue;
        logic             first;
        logic             last;
    } obb_cmd_t;

    // Store row of a vector
    function automatic logic [ROW_W-1:0] vec_row(input logic b, input logic [1:0] s);
        vec_row = {b, s};
    endfunction

    // Row of half-axis n (0..5): box 0 slots 1..3, then box 1 slots 1..3
    function automatic logic [ROW_W-1:0] half_row(input logic [2:0] n);
        logic [ROW_W-1:0] r;
        case (n)
            3'd0:    r = vec_row(1'b0, 2'd1);
            3'd1:    r = vec_row(1'b0, 2'd2);
            3'd2:    r = vec_row(1'b0, 2'd3);
            3'd3:    r = vec_row(1'b1, 2'd1);
            3'd4:    r = vec_row(1'b1, 2'd2);
            3'd5:    r = vec_row(1'b1, 2'd3);
            default: r = vec_row(1'b0, 2'd0);
        endcase
        half_row = r;
    endfunction

endpackage

/* hw/rtl/obbfaot_dp.sv */
// ----------------------------------------------------------------------------
// obbfaot_dp
// Vector store and dot-product pipeline: read, multiply, sum/abs, accumulate
// and compare. One dot product enters per cycle.
// ----------------------------------------------------------------------------
module obbfaot_dp
    import obbfaot_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  obb_cmd_t                      cmd,
    input  logic signed [COORD_WIDTH-1:0] vec_x,
    input  logic signed [COORD_WIDTH-1:0] vec_y,
    input  logic signed [COORD_WIDTH-1:0] vec_z,
    output logic                          hit
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;       // center offset component
    localparam int PW = 2 * W + 1;   // one product
    localparam int SW = 2 * W + 3;   // dot product and its magnitude
    localparam int AW = 2 * W + 6;   // sum of six magnitudes

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tag_t;

    logic [3*W-1:0]          vec_mem_reg [VEC_ROWS];
    logic [3*W-1:0]          rd_a_reg;
    logic [3*W-1:0]          rd_b_reg;
    logic signed [DW-1:0]    d_reg    [3];
    logic signed [DW-1:0]    d_next   [3];
    logic signed [PW-1:0]    prod_reg [3];
    logic signed [PW-1:0]    prod_next[3];
    logic signed [DW-1:0]    op       [3];
    logic signed [W-1:0]     ax       [3];
    logic signed [W-1:0]     va       [3];
    logic signed [W-1:0]     vb       [3];
    logic signed [SW-1:0]    dot_sum;
    logic [SW-1:0]           dot_mag;
    logic [SW-1:0]           abs_reg;
    logic [SW-1:0]           dist_reg;
    logic [AW-1:0]           rad_reg;
    logic [AW-1:0]           rad_sum;
    logic                    sep_reg;
    logic                    sep_next;
    tag_t                    s1_reg, s2_reg, s3_reg;
    tag_t                    s1_next;

    // Vector store: one write row, two registered read rows
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            vec_mem_reg[cmd.wr_row] <= {vec_z, vec_y, vec_x};
        end
        rd_a_reg <= vec_mem_reg[cmd.rd_a_row];
        rd_b_reg <= vec_mem_reg[cmd.rd_b_row];
    end

    // Component split of the read rows, center offset and operand products
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            va[c] = $signed(rd_a_reg[c*W +: W]);
            vb[c] = $signed(rd_b_reg[c*W +: W]);
            ax[c] = va[c];
            d_next[c] = DW'(vb[c]) - DW'(va[c]);
            op[c] = s1_reg.first ? d_reg[c] : DW'(vb[c]);
            prod_next[c] = PW'(op[c]) * PW'(ax[c]);
        end
    end

    // Dot product sum and magnitude
    always_comb
    begin
        dot_sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
        dot_mag = dot_sum[SW-1] ? SW'(-dot_sum) : SW'(dot_sum);
    end

    // Accumulate radius; on the last term compare against the distance; sep_clr clears the flag
    always_comb
    begin
        rad_sum  = rad_reg + AW'(abs_reg);
        sep_next = sep_reg;
        if (cmd.sep_clr)
        begin
            sep_next = 1'b0;
        end
        else if (s3_reg.valid && s3_reg.last && (AW'(dist_reg) > rad_sum))
        begin
            sep_next = 1'b1;
        end
    end

    assign s1_next = '{valid: cmd.issue, first: cmd.first, last: cmd.last};

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.d_load)
        begin
            for (int c = 0; c < 3; c++)
            begin
                d_reg[c] <= d_next[c];
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            prod_reg[c] <= prod_next[c];
        end
        abs_reg <= dot_mag;
        if (s3_reg.valid)
        begin
            if (s3_reg.first)
            begin
                dist_reg <= abs_reg;
                rad_reg  <= '0;
            end
            else
            begin
                rad_reg <= rad_sum;
            end
        end
    end

    // Control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            sep_reg <= 1'b0;
        end
        else
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s1_reg;
            s3_reg  <= s2_reg;
            sep_reg <= sep_next;
        end
    end

    assign hit = ~sep_reg;

endmodule

/* hw/rtl/obbfaot_ctrl.sv */
// ----------------------------------------------------------------------------
// obbfaot_ctrl
// Command controller: takes input beats, writes loads, and sequences the
// center read, offset capture, 42-term axis sweep, pipeline drain and result.
// ----------------------------------------------------------------------------
module obbfaot_ctrl
    import obbfaot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       command,
    input  logic       box,
    input  logic [1:0] slot,
    output logic       busy,
    output logic       done,
    output obb_cmd_t   cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CENTER = 6'b000010,
        ST_DIFF   = 6'b000100,
        ST_SWEEP  = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t     state_reg,  state_next;
    logic [2:0] axis_reg,   axis_next;
    logic [2:0] term_reg,   term_next;
    logic [1:0] drain_reg,  drain_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_DONE);
    assign accept = start && !busy;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        term_next  = term_reg;
        drain_next = drain_reg;

        cmd          = '0;
        cmd.wr_en    = accept && (command == CMD_LOAD);
        cmd.wr_row   = vec_row(box, slot);
        cmd.rd_a_row = half_row(axis_reg);
        cmd.rd_b_row = half_row(term_reg - 3'd1);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_TEST))
                begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                cmd.rd_a_row = vec_row(1'b0, 2'd0);
                cmd.rd_b_row = vec_row(1'b1, 2'd0);
                cmd.sep_clr  = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.d_load = 1'b1;
                axis_next  = '0;
                term_next  = '0;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.issue = 1'b1;
                cmd.first = (term_reg == '0);
                cmd.last  = (term_reg == TERM_LAST);
                if (term_reg == TERM_LAST)
                begin
                    term_next = '0;
                    if (axis_reg == AXIS_LAST)
                    begin
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        axis_next = axis_reg + 3'd1;
                    end
                end
                else
                begin
                    term_next = term_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            term_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            term_reg  <= term_next;
            drain_reg <= drain_next;
        end
    end

`ifndef ASSERT_OFF
    // Result strobe is a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted test beat starts the center read
    a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_TEST)) |=> (state_reg == ST_CENTER))
        else $error("test beat not started");

    // Sweep counters stay within the axis and term range
    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> ((term_reg <= TERM_LAST) && (axis_reg <= AXIS_LAST)))
        else $error("sweep counter out of range");

    // Busy only drops after a result was given
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");
`endif

endmodule

/* hw/rtl/obb_face_axis_overlap_test_top.sv */
// ----------------------------------------------------------------------------
// obb_face_axis_overlap_test_top
// Two-box face-axis separating test with a loadable vector store.
// ----------------------------------------------------------------------------
// A load beat (command 0) writes one vector in the cycle it is accepted and
// leaves busy low, so loads can come every cycle while no test runs. A test
// beat (command 1) raises busy while it reads both centers, forms their
// offset, streams the dot products (six axes, seven terms each, one per
// cycle through a three-multiplier pipeline), drains that pipeline and
// pulses done with hit. The next beat can be accepted at the edge after the
// done cycle. done is a one-cycle strobe that the receiver cannot hold off.
// Test only after all eight vectors were loaded.
// ----------------------------------------------------------------------------
module obb_face_axis_overlap_test_top
    import obbfaot_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic                          box,
    input  logic [1:0]                    slot,
    input  logic signed [COORD_WIDTH-1:0] vec_x,
    input  logic signed [COORD_WIDTH-1:0] vec_y,
    input  logic signed [COORD_WIDTH-1:0] vec_z,
    output logic                          done,
    output logic                          hit
);

    obb_cmd_t cmd;

    // Sequencer
    obbfaot_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .box     (box),
        .slot    (slot),
        .busy    (busy),
        .done    (done),
        .cmd     (cmd)
    );

    // Store and arithmetic
    obbfaot_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .vec_x (vec_x),
        .vec_y (vec_y),
        .vec_z (vec_z),
        .hit   (hit)
    );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-box face-axis overlap tester.
// ----------------------------------------------------------------------------
// Beats are driven on the falling edge in bursts with random gaps. Each
// accepted load updates a local copy of the vector store. Each accepted test
// runs an exact wide-integer separating-axis check on that copy and queues
// the expected hit flag. A checker compares every done strobe against the
// oldest queued flag. Directed scenes come first, then random box pairs.
// ----------------------------------------------------------------------------
module tb_top
    import obbfaot_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = 24;
    localparam int RAND_BEATS = 400;
    localparam int DRAIN_CYC  = 60;

    typedef logic signed [CW-1:0]  coord_t;
    typedef logic signed [127:0]   wide_t;

    localparam coord_t C_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t C_MIN  = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t C_ONE  = coord_t'(4096);

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       command = CMD_LOAD;
    logic       box = 1'b0;
    logic [1:0] slot = 2'd0;
    coord_t     vec_x = '0;
    coord_t     vec_y = '0;
    coord_t     vec_z = '0;
    logic       done;
    logic       hit;

    // Local copy of the vector store, row = {box, slot}
    coord_t     vec_store [8][3];
    logic       pending_hits [$];

    int         fail_cnt    = 0;
    int         beats_sent  = 0;
    int         load_cnt    = 0;
    int         test_cnt    = 0;
    int         overlap_cnt = 0;
    int         burst_left  = 0;

    obb_face_axis_overlap_test_top #(
        .COORD_WIDTH (CW)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .box     (box),
        .slot    (slot),
        .vec_x   (vec_x),
        .vec_y   (vec_y),
        .vec_z   (vec_z),
        .done    (done),
        .hit     (hit)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Projection of a vector onto the axis stored in row axis_row
    function automatic wide_t dot_axis(input wide_t v0, input wide_t v1, input wide_t v2,
                                       input int axis_row);
        wide_t a0, a1, a2;
        a0 = wide_t'(vec_store[axis_row][0]);
        a1 = wide_t'(vec_store[axis_row][1]);
        a2 = wide_t'(vec_store[axis_row][2]);
        return v0 * a0 + v1 * a1 + v2 * a2;
    endfunction

    function automatic wide_t mag(input wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // Exact face-axis test on the local store: 1 when no axis separates
    function automatic logic predict_overlap();
        wide_t off [3];
        wide_t proj, reach;
        int    ar, hr;
        for (int c = 0; c < 3; c++)
            off[c] = wide_t'(vec_store[4][c]) - wide_t'(vec_store[0][c]);
        for (int n = 0; n < 6; n++)
        begin
            ar    = (n < 3) ? n + 1 : n + 2;
            proj  = mag(dot_axis(off[0], off[1], off[2], ar));
            reach = '0;
            for (int k = 0; k < 6; k++)
            begin
                hr    = (k < 3) ? k + 1 : k + 2;
                reach = reach + mag(dot_axis(wide_t'(vec_store[hr][0]),
                                             wide_t'(vec_store[hr][1]),
                                             wide_t'(vec_store[hr][2]), ar));
            end
            if (proj > reach)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Signed random value that fits in the given number of bits
    function automatic coord_t rand_coord(input int bits);
        logic signed [31:0] r;
        r = $urandom;
        return coord_t'(r >>> (32 - bits));
    endfunction

    // Drive one beat, hold it until accepted, then update the prediction
    task automatic send_beat(input cmd_code_t cmd, input logic b, input logic [1:0] s,
                             input coord_t x, input coord_t y, input coord_t z);
        int gap;
        logic exp_hit;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start   <= 1'b1;
        command <= cmd;
        box     <= b;
        slot    <= s;
        vec_x   <= x;
        vec_y   <= y;
        vec_z   <= z;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        if (cmd == CMD_LOAD)
        begin
            vec_store[{b, s}][0] = x;
            vec_store[{b, s}][1] = y;
            vec_store[{b, s}][2] = z;
            load_cnt++;
        end
        else
        begin
            exp_hit = predict_overlap();
            pending_hits.push_back(exp_hit);
            test_cnt++;
            if (exp_hit)
                overlap_cnt++;
        end
    endtask

    task automatic load_vec(input logic b, input logic [1:0] s,
                            input coord_t x, input coord_t y, input coord_t z);
        send_beat(CMD_LOAD, b, s, x, y, z);
    endtask

    // Test beat; the unused fields carry random junk
    task automatic run_overlap();
        send_beat(CMD_TEST, 1'($urandom), 2'($urandom), rand_coord(CW), rand_coord(CW),
                  rand_coord(CW));
    endtask

    // Result checker: one done strobe per queued flag
    always @(posedge clk)
    begin
        logic exp_hit;
        if (rst_n && done)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("hit: unexpected result, actual %0b", hit);
                fail_cnt++;
            end
            else
            begin
                exp_hit = pending_hits.pop_front();
                if (hit !== exp_hit)
                begin
                    $error("hit: expected %0b, actual %0b", exp_hit, hit);
                    fail_cnt++;
                end
            end
        end
    end

    // Every slot of both boxes at extreme values (C_MAX, C_MIN, 0, -1), then a test
    task automatic test_store_extremes();
        load_vec(1'b0, 2'd0, C_MAX, C_MIN, '0);
        load_vec(1'b0, 2'd1, C_MIN, C_MIN, C_MIN);
        load_vec(1'b0, 2'd2, C_MAX, C_MAX, C_MAX);
        load_vec(1'b0, 2'd3, '1, '0, C_MAX);
        load_vec(1'b1, 2'd0, C_MIN, C_MAX, '1);
        load_vec(1'b1, 2'd1, C_MAX, '0, C_MIN);
        load_vec(1'b1, 2'd2, '0, C_MIN, C_MAX);
        load_vec(1'b1, 2'd3, C_MIN, '1, '0);
        run_overlap();
    endtask

    // Unit cubes: overlap, exact touch, separation, zero-length axis, coincident centers
    task automatic test_unit_cubes();
        load_vec(1'b0, 2'd0, '0, '0, '0);
        load_vec(1'b0, 2'd1, C_ONE, '0, '0);
        load_vec(1'b0, 2'd2, '0, C_ONE, '0);
        load_vec(1'b0, 2'd3, '0, '0, C_ONE);
        load_vec(1'b1, 2'd1, C_ONE, '0, '0);
        load_vec(1'b1, 2'd2, '0, C_ONE, '0);
        load_vec(1'b1, 2'd3, '0, '0, C_ONE);
        load_vec(1'b1, 2'd0, coord_t'(6144), '0, '0);
        run_overlap();
        // faces touch: both sides equal, still a hit
        load_vec(1'b1, 2'd0, coord_t'(8192), '0, '0);
        run_overlap();
        load_vec(1'b1, 2'd0, '0, '0, coord_t'(-10240));
        run_overlap();
        // zero-length axis in box 1 never separates
        load_vec(1'b1, 2'd3, '0, '0, '0);
        run_overlap();
        // coincident centers
        load_vec(1'b1, 2'd0, '0, '0, '0);
        run_overlap();
    endtask

    // Random box pairs, with center moves and full-range noise loads
    task automatic test_random_scenes();
        int     pick, sc, cs, first;
        coord_t c0 [3];
        while (beats_sent < RAND_BEATS)
        begin
            pick = $urandom_range(0, 9);
            sc   = $urandom_range(3, 20);
            cs   = sc + $urandom_range(0, 3);
            if (pick < 6)
            begin
                // fresh pair of boxes, rows written starting at a random row
                first = $urandom_range(0, 7);
                for (int i = 0; i < 8; i++)
                begin
                    int r;
                    r = (first + i) % 8;
                    if (r[1:0] == 2'd0)
                        load_vec(r[2], 2'd0, rand_coord(cs), rand_coord(cs), rand_coord(cs));
                    else
                        load_vec(r[2], r[1:0], rand_coord(sc), rand_coord(sc),
                                 rand_coord(sc));
                end
                run_overlap();
            end
            else if (pick < 8)
            begin
                // move centers only, box 1 center relative to the new box 0 center
                for (int c = 0; c < 3; c++)
                    c0[c] = rand_coord(cs);
                load_vec(1'b0, 2'd0, c0[0], c0[1], c0[2]);
                load_vec(1'b1, 2'd0, c0[0] + rand_coord(cs - 1), c0[1] + rand_coord(cs - 1),
                         c0[2] + rand_coord(cs - 1));
                run_overlap();
            end
            else
            begin
                // noise: full-range loads to random rows, maybe back-to-back tests
                repeat ($urandom_range(0, 3))
                    load_vec(1'($urandom), 2'($urandom), rand_coord(CW), rand_coord(CW),
                             rand_coord(CW));
                run_overlap();
                if ($urandom_range(0, 1) == 1)
                    run_overlap();
            end
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_store_extremes();
        test_unit_cubes();
        test_random_scenes();

        @(negedge clk);
        start <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Covered %0d load beats and %0d overlap tests (%0d overlapping, %0d apart).",
                 load_cnt, test_cnt, overlap_cnt, test_cnt - overlap_cnt);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/obbfaot_pkg.sv
hw/rtl/obbfaot_dp.sv
hw/rtl/obbfaot_ctrl.sv
hw/rtl/obb_face_axis_overlap_test_top.sv
verif/tb_top.sv
